// ===== hw/rtl/tssa_pkg.sv =====
// Shared types, constants and the wake-up helper of the two-side shared resource arbiter.
// Used by every module of the block; depends on nothing else.
package tssa_pkg;

  localparam int unsigned MaxCapacity = 16;
  localparam int unsigned MaxWaiting  = 255;

  localparam int unsigned CntW   = 5;  // present and admitted counts, 0..MaxCapacity
  localparam int unsigned WaitW  = 8;  // wait counts, 0..MaxWaiting
  localparam int unsigned BatchW = 6;  // batch counts and batch limit

  typedef logic [CntW-1:0]   cnt_t;
  typedef logic [WaitW-1:0]  wait_t;
  typedef logic [BatchW-1:0] batch_t;

  localparam cnt_t   MaxCapCnt  = CntW'(MaxCapacity);
  localparam wait_t  MaxWaitCnt = WaitW'(MaxWaiting);
  localparam batch_t BatchSat   = '1;

  localparam cnt_t   CapReset   = 5'd4;
  localparam batch_t LimReset   = 6'd8;

  // Configuration register indexes
  localparam logic CfgCapacity   = 1'b0;
  localparam logic CfgBatchLimit = 1'b1;

  // Event kinds
  localparam logic ActArrive = 1'b0;
  localparam logic ActDepart = 1'b1;

  typedef enum logic [1:0] {
    ErrOk          = 2'd0,
    ErrWaitFull    = 2'd1,
    ErrNonePresent = 2'd2
  } err_e;

  typedef struct packed {
    cnt_t  count;
    logic  side;
    logic  queued;
    err_e  err;
    cnt_t  users;
    wait_t wait0;
    wait_t wait1;
  } result_t;

  typedef struct packed {
    wait_t  w;
    cnt_t   p;
    batch_t b;
    cnt_t   n;
  } wake_t;

  // Admit one waiter if room allows, then a run bounded by waiters, room and batch allowance.
  function automatic wake_t wake(wait_t w, cnt_t p, batch_t b, cnt_t cap, batch_t lim);
    wake_t         r;
    wait_t         w1;
    cnt_t          p1;
    batch_t        b1;
    wait_t         more;
    wait_t         room;
    wait_t         allow;
    logic [BatchW:0] bsum;
    r.w = w;
    r.p = p;
    r.b = b;
    r.n = '0;
    if (w != '0 && p < cap) begin
      w1   = w - 1'b1;
      p1   = p + 1'b1;
      b1   = (b < BatchSat) ? b + 1'b1 : b;
      more = '0;
      if (p1 < cap && b1 < lim) begin
        room  = WaitW'(cap - p1);
        allow = WaitW'(lim - b1);
        more  = w1;
        if (room < more) more = room;
        if (allow < more) more = allow;
      end
      bsum = {1'b0, b1} + (BatchW+1)'(more);
      r.w  = w1 - more;
      r.p  = p1 + CntW'(more);
      r.b  = (bsum > {1'b0, BatchSat}) ? BatchSat : bsum[BatchW-1:0];
      r.n  = CntW'(more) + 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/two_side_shared_resource_arbiter_top.sv =====
// Top level of the two-side shared resource arbiter (one-lane bridge scheduler).
// Depends on tssa_pkg, tssa_cfg, tssa_core and tssa_out.
//
// Usage:
//   Slave channel: one event per transaction; s_tdata[0] is the action (0 arrive,
//   1 depart), s_tuser is the side (0 first, 1 second).
//   Master channel: one result transaction per event, in event order.
//   Configuration: cfg_we_i with cfg_idx_i 0 writes capacity (low 5 bits of
//   cfg_wdata_i), index 1 writes the batch limit; write only while idle.
// Timing:
//   An accepted event is held in the input register, is resolved there against the
//   per-side counters, and is then loaded into the result register, which drives
//   m_tvalid. The counter update is a single short combinational pass, so one event
//   per cycle is sustained while m_tready stays high.
// Reset:
//   All counts clear to zero, capacity returns to 4 and batch limit to 8; both
//   channels come up empty.
// Stall:
//   When m_tready is low the result holds; the input register still fills, and
//   s_tready drops only once both registers are occupied.
module two_side_shared_resource_arbiter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] action, [7:1] zero
  input  logic        s_tuser,   // [0] side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [4:0] admitted_count, [5] arrival_queued,
                                 // [7:6] error_code, [12:8] users_present,
                                 // [20:13] first_waiting, [28:21] second_waiting, [31:29] zero
  output logic        m_tuser,   // [0] admitted_side
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [5:0]  cfg_wdata_i
);

  logic              in_valid_q, in_valid_d;
  logic              action_q, side_q;
  logic              adv, out_free;
  tssa_pkg::cnt_t    cap;
  tssa_pkg::batch_t  lim;
  tssa_pkg::result_t res_comb, res_out;

  tssa_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cap_o       (cap),
    .lim_o       (lim)
  );

  // Advance the held event into the result register when that register is free.
  assign adv        = in_valid_q && out_free;
  assign s_tready   = !in_valid_q || adv;
  assign in_valid_d = (s_tvalid && s_tready) || (in_valid_q && !adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Capture the event payload on every accepted transaction.
  always_ff @(posedge clk_i) begin
    if (s_tvalid && s_tready) begin
      action_q <= s_tdata[0];
      side_q   <= s_tuser;
    end
  end

  tssa_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .action_i (action_q),
    .side_i   (side_q),
    .cap_i    (cap),
    .lim_i    (lim),
    .res_o    (res_comb)
  );

  tssa_out u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (adv),
    .res_i    (res_comb),
    .ready_i  (m_tready),
    .valid_o  (m_tvalid),
    .free_o   (out_free),
    .res_o    (res_out)
  );

  // Pack the result fields from the lowest bit up.
  assign m_tdata = {3'b000, res_out.wait1, res_out.wait0, res_out.users,
                    res_out.err, res_out.queued, res_out.count};
  assign m_tuser = res_out.side;

endmodule

// ===== hw/rtl/tssa_cfg.sv =====
// Configuration registers of the arbiter and their effective (clamped) values.
// Depends on tssa_pkg.
module tssa_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  tssa_pkg::batch_t    cfg_wdata_i,
  output tssa_pkg::cnt_t      cap_o,
  output tssa_pkg::batch_t    lim_o
);

  tssa_pkg::cnt_t   cap_q, cap_d;
  tssa_pkg::batch_t lim_q, lim_d;

  always_comb begin
    cap_d = cap_q;
    lim_d = lim_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tssa_pkg::CfgCapacity:   cap_d = cfg_wdata_i[tssa_pkg::CntW-1:0];
        tssa_pkg::CfgBatchLimit: lim_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= tssa_pkg::CapReset;
      lim_q <= tssa_pkg::LimReset;
    end else begin
      cap_q <= cap_d;
      lim_q <= lim_d;
    end
  end

  // zero acts as one; capacity clamps to the maximum
  assign cap_o = (cap_q == '0) ? tssa_pkg::cnt_t'(1) :
                 (cap_q > tssa_pkg::MaxCapCnt) ? tssa_pkg::MaxCapCnt : cap_q;
  assign lim_o = (lim_q == '0) ? tssa_pkg::batch_t'(1) : lim_q;

endmodule

// ===== hw/rtl/tssa_core.sv =====
// Per-side counters and the combinational event update of the arbiter.
// Depends on tssa_pkg.
module tssa_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               action_i,
  input  logic               side_i,
  input  tssa_pkg::cnt_t     cap_i,
  input  tssa_pkg::batch_t   lim_i,
  output tssa_pkg::result_t  res_o
);

  tssa_pkg::wait_t  wait_q  [2];
  tssa_pkg::wait_t  wait_d  [2];
  tssa_pkg::cnt_t   pres_q  [2];
  tssa_pkg::cnt_t   pres_d  [2];
  tssa_pkg::batch_t batch_q [2];
  tssa_pkg::batch_t batch_d [2];

  tssa_pkg::wait_t  own_w, oth_w, nown_w, noth_w;
  tssa_pkg::cnt_t   own_p, oth_p, nown_p, noth_p, dep_p;
  tssa_pkg::batch_t own_b, oth_b, nown_b, noth_b, dep_b;
  logic             blocked, hand_over;
  tssa_pkg::wake_t  wk;

  // own side follows the event, other side is its opposite
  assign own_w = side_i ? wait_q[1]  : wait_q[0];
  assign oth_w = side_i ? wait_q[0]  : wait_q[1];
  assign own_p = side_i ? pres_q[1]  : pres_q[0];
  assign oth_p = side_i ? pres_q[0]  : pres_q[1];
  assign own_b = side_i ? batch_q[1] : batch_q[0];
  assign oth_b = side_i ? batch_q[0] : batch_q[1];

  assign blocked   = (oth_p != '0) || (own_p >= cap_i) || (own_b >= lim_i) || (own_w != '0);
  assign dep_p     = own_p - 1'b1;
  assign dep_b     = (dep_p == '0) ? '0 : own_b;
  assign hand_over = (dep_p == '0) && (oth_w != '0);

  assign wk = hand_over ? tssa_pkg::wake(oth_w, oth_p, oth_b, cap_i, lim_i)
                        : tssa_pkg::wake(own_w, dep_p, dep_b, cap_i, lim_i);

  always_comb begin
    nown_w = own_w;
    nown_p = own_p;
    nown_b = own_b;
    noth_w = oth_w;
    noth_p = oth_p;
    noth_b = oth_b;
    res_o.count  = '0;
    res_o.side   = side_i;
    res_o.queued = 1'b0;
    res_o.err    = tssa_pkg::ErrOk;
    if (action_i == tssa_pkg::ActArrive) begin
      if (blocked) begin
        if (own_w >= tssa_pkg::MaxWaitCnt) begin
          res_o.err = tssa_pkg::ErrWaitFull;
        end else begin
          nown_w       = own_w + 1'b1;
          res_o.queued = 1'b1;
        end
      end else begin
        nown_p      = own_p + 1'b1;
        nown_b      = (own_b < tssa_pkg::BatchSat) ? own_b + 1'b1 : own_b;
        res_o.count = tssa_pkg::cnt_t'(1);
      end
    end else if (own_p == '0) begin
      res_o.err = tssa_pkg::ErrNonePresent;
    end else begin
      nown_p = dep_p;
      nown_b = dep_b;
      if (hand_over) begin
        noth_w      = wk.w;
        noth_p      = wk.p;
        noth_b      = wk.b;
        res_o.count = wk.n;
        res_o.side  = ~side_i;
      end else if (own_w != '0 && (dep_b < lim_i || oth_w == '0)) begin
        nown_w      = wk.w;
        nown_p      = wk.p;
        nown_b      = wk.b;
        res_o.count = wk.n;
      end
    end
    wait_d[0]  = side_i ? noth_w : nown_w;
    wait_d[1]  = side_i ? nown_w : noth_w;
    pres_d[0]  = side_i ? noth_p : nown_p;
    pres_d[1]  = side_i ? nown_p : noth_p;
    batch_d[0] = side_i ? noth_b : nown_b;
    batch_d[1] = side_i ? nown_b : noth_b;
    res_o.users = (pres_d[0] != '0) ? pres_d[0] : pres_d[1];
    res_o.wait0 = wait_d[0];
    res_o.wait1 = wait_d[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q[0]  <= '0;
      wait_q[1]  <= '0;
      pres_q[0]  <= '0;
      pres_q[1]  <= '0;
      batch_q[0] <= '0;
      batch_q[1] <= '0;
    end else if (adv_i) begin
      wait_q[0]  <= wait_d[0];
      wait_q[1]  <= wait_d[1];
      pres_q[0]  <= pres_d[0];
      pres_q[1]  <= pres_d[1];
      batch_q[0] <= batch_d[0];
      batch_q[1] <= batch_d[1];
    end
  end

endmodule

// ===== hw/rtl/tssa_out.sv =====
// Result register of the arbiter: holds one result transaction until the receiver takes it.
// Depends on tssa_pkg.
module tssa_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  tssa_pkg::result_t  res_i,
  input  logic               ready_i,
  output logic               valid_o,
  output logic               free_o,
  output tssa_pkg::result_t  res_o
);

  logic              valid_q, valid_d;
  tssa_pkg::result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== hw/rtl/tssa_chk.sv =====
// Port-level checker of the arbiter, bound to the top level.
// Depends on tssa_pkg and two_side_shared_resource_arbiter_top.
module tssa_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // A stalled result transaction holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // A refused event admits and queues nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tdata[7:6] != tssa_pkg::ErrOk |-> m_tdata[4:0] == '0 && !m_tdata[5])
    else $error("error result with admission or queueing");

  // A queued arrival admits nobody.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tdata[5] |-> m_tdata[4:0] == '0 && m_tdata[7:6] == tssa_pkg::ErrOk)
    else $error("queued arrival with admission");

  // A result never shows more users or admissions than the largest capacity, nor an unknown error code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> m_tdata[12:8] <= tssa_pkg::MaxCapCnt && m_tdata[4:0] <= tssa_pkg::MaxCapCnt &&
                 m_tdata[7:6] <= tssa_pkg::ErrNonePresent)
    else $error("result count out of range");

endmodule

bind two_side_shared_resource_arbiter_top tssa_chk u_chk (.*);

// ===== verif/tb_two_side_shared_resource_arbiter_top.sv =====
// Self-checking testbench for two_side_shared_resource_arbiter_top: directed and random
// arrive/depart traffic over several capacity and batch-limit settings, every result checked.
// Depends on tssa_pkg and the top level of the arbiter.
module tb_two_side_shared_resource_arbiter_top;

  localparam int unsigned Period   = 12;
  localparam int unsigned Settle   = 4;       // result latency plus margin

  typedef enum logic [1:0] {
    TrafficMixed,
    TrafficOneSide,
    TrafficFlood
  } traffic_e;

  // Counters of both sides plus the raw register values, as the block holds them
  typedef struct packed {
    tssa_pkg::wait_t  [1:0] waiting;
    tssa_pkg::cnt_t   [1:0] present;
    tssa_pkg::batch_t [1:0] batch;
    logic   [4:0]           cap;
    tssa_pkg::batch_t       lim;
  } arb_state_t;

  typedef struct packed {
    logic act;
    logic side;
  } arb_event_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        s_tvalid    = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata     = '0;
  logic        s_tuser     = 1'b0;
  logic        m_tvalid;
  logic        m_tready    = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_idx_i   = tssa_pkg::CfgCapacity;
  logic [5:0]  cfg_wdata_i = '0;

  two_side_shared_resource_arbiter_top dut (
    .clk_i,
    .rst_ni,
    .s_tvalid,
    .s_tready,
    .s_tdata,
    .s_tuser,
    .m_tvalid,
    .m_tready,
    .m_tdata,
    .m_tuser,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i
  );

  arb_event_t         pending_events[$];
  tssa_pkg::result_t  expected_results[$];
  arb_state_t  model_st;     // advanced on each accepted transaction
  arb_state_t  plan_st;      // advanced as events are queued, steers the traffic
  int unsigned idle_pct;
  int unsigned src_gap;
  int unsigned snk_gap;
  int unsigned mismatches;
  int unsigned n_results;
  int unsigned n_queued;
  int unsigned n_refused;
  int unsigned n_empty_depart;
  int unsigned n_settings;
  int unsigned widest_run;

  initial begin
    forever #(Period / 2) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic int unsigned eff_cap(arb_state_t st);
    if (st.cap == '0) return 1;
    if (st.cap > tssa_pkg::MaxCapacity) return tssa_pkg::MaxCapacity;
    return 32'(st.cap);
  endfunction

  function automatic int unsigned eff_lim(arb_state_t st);
    return (st.lim == '0) ? 1 : 32'(st.lim);
  endfunction

  // Admit one waiter of side s regardless of the batch limit, then a run bounded by
  // remaining waiters, room and batch allowance. Return the number admitted.
  function automatic int unsigned admit_run(inout arb_state_t st, input logic s);
    int unsigned capn;
    int unsigned limn;
    int unsigned w;
    int unsigned p;
    int unsigned b;
    int unsigned more;
    capn = eff_cap(st);
    limn = eff_lim(st);
    w    = 32'(st.waiting[s]);
    p    = 32'(st.present[s]);
    b    = 32'(st.batch[s]);
    if (w == 0 || p >= capn) return 0;
    w = w - 1;
    p = p + 1;
    if (b < tssa_pkg::BatchSat) b = b + 1;
    more = 0;
    if (p < capn && b < limn) begin
      more = w;
      if (capn - p < more) more = capn - p;
      if (limn - b < more) more = limn - b;
    end
    w = w - more;
    p = p + more;
    b = (b + more > tssa_pkg::BatchSat) ? 32'(tssa_pkg::BatchSat) : b + more;
    st.waiting[s] = tssa_pkg::wait_t'(w);
    st.present[s] = tssa_pkg::cnt_t'(p);
    st.batch[s]   = tssa_pkg::batch_t'(b);
    return more + 1;
  endfunction

  function automatic tssa_pkg::result_t resolve_event(inout arb_state_t st, input logic act,
                                                      input logic s);
    tssa_pkg::result_t r;
    logic              o;
    int unsigned       capn;
    int unsigned       limn;
    o      = ~s;
    capn   = eff_cap(st);
    limn   = eff_lim(st);
    r      = '0;
    r.side = s;
    r.err  = tssa_pkg::ErrOk;
    if (act == tssa_pkg::ActArrive) begin
      if (st.present[o] != '0 || st.present[s] >= capn || st.batch[s] >= limn ||
          st.waiting[s] != '0) begin
        if (st.waiting[s] >= tssa_pkg::MaxWaiting) begin
          r.err = tssa_pkg::ErrWaitFull;
        end else begin
          st.waiting[s] = st.waiting[s] + 1'b1;
          r.queued = 1'b1;
        end
      end else begin
        st.present[s] = st.present[s] + 1'b1;
        if (st.batch[s] < tssa_pkg::BatchSat) st.batch[s] = st.batch[s] + 1'b1;
        r.count = 5'd1;
      end
    end else if (st.present[s] == '0) begin
      r.err = tssa_pkg::ErrNonePresent;
    end else begin
      st.present[s] = st.present[s] - 1'b1;
      // an emptied side always restarts its batch
      if (st.present[s] == '0) st.batch[s] = '0;
      if (st.present[s] == '0 && st.waiting[o] != '0) begin
        r.count = tssa_pkg::cnt_t'(admit_run(st, o));
        r.side  = o;
      end else if (st.waiting[s] != '0 && (st.batch[s] < limn || st.waiting[o] == '0)) begin
        r.count = tssa_pkg::cnt_t'(admit_run(st, s));
      end
    end
    r.users = (st.present[0] != '0) ? st.present[0] : st.present[1];
    r.wait0 = st.waiting[0];
    r.wait1 = st.waiting[1];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feed one event per transaction, with random bursts of idle cycles
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    arb_event_t ev;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      src_gap  <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(resolve_event(model_st, s_tdata[0], s_tuser));
      end
      // Advance only when the slot is free; otherwise hold the offered event
      if (!s_tvalid || s_tready) begin
        if (src_gap != 0) begin
          src_gap  <= src_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_events.size() != 0) begin
          ev       = pending_events.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {7'b0, ev.act};
          s_tuser  <= ev.side;
          if ($urandom_range(99) < idle_pct) src_gap <= $urandom_range(4, 1);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result transaction against the oldest expectation
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("result %0d: %s got %0d, want %0d", n_results, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    tssa_pkg::result_t want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
      snk_gap  <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          note_mismatch("result with nothing expected, m_tdata", m_tdata, 0);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[4:0] != want.count)
            note_mismatch("admitted_count", m_tdata[4:0], want.count);
          if (m_tuser != want.side)
            note_mismatch("admitted_side", m_tuser, want.side);
          if (m_tdata[5] != want.queued)
            note_mismatch("arrival_queued", m_tdata[5], want.queued);
          if (m_tdata[7:6] != want.err)
            note_mismatch("error_code", m_tdata[7:6], want.err);
          if (m_tdata[12:8] != want.users)
            note_mismatch("users_present", m_tdata[12:8], want.users);
          if (m_tdata[20:13] != want.wait0)
            note_mismatch("first_waiting", m_tdata[20:13], want.wait0);
          if (m_tdata[28:21] != want.wait1)
            note_mismatch("second_waiting", m_tdata[28:21], want.wait1);
          if (want.queued) n_queued++;
          if (want.err == tssa_pkg::ErrWaitFull) n_refused++;
          if (want.err == tssa_pkg::ErrNonePresent) n_empty_depart++;
          if (want.count > widest_run) widest_run = 32'(want.count);
        end
        n_results++;
      end
      // Stall the result side in short random bursts
      if (snk_gap != 0) begin
        snk_gap  <= snk_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(99) < idle_pct) snk_gap <= $urandom_range(4, 1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_event(input logic act, input logic side);
    arb_event_t ev;
    ev.act  = act;
    ev.side = side;
    void'(resolve_event(plan_st, act, side));
    pending_events.push_back(ev);
  endtask

  // Pick the next event from the planned state so most traffic is well formed:
  // departures mostly come from the side that holds the resource.
  task automatic plan_event(input traffic_e mode, input logic fav);
    int unsigned r;
    logic        o;
    logic        active;
    r      = $urandom_range(99);
    o      = ~fav;
    active = (plan_st.present[0] != '0) ? 1'b0 : 1'b1;
    if (r < 5) begin
      // noise: any event, including departures from an empty side
      queue_event(1'($urandom_range(1)), 1'($urandom_range(1)));
    end else if (mode == TrafficMixed) begin
      if (plan_st.present != '0 && r < 50) queue_event(tssa_pkg::ActDepart, active);
      else queue_event(tssa_pkg::ActArrive, 1'($urandom_range(1)));
    end else if (mode == TrafficOneSide) begin
      // keep the favored side on the resource so its batch count climbs
      if (plan_st.present[fav] == '0 && plan_st.present[o] != '0)
        queue_event(tssa_pkg::ActDepart, o);
      else if (plan_st.present[fav] > 1 && r < 45) queue_event(tssa_pkg::ActDepart, fav);
      else queue_event(tssa_pkg::ActArrive, fav);
    end else begin
      // flood: hold the other side on the resource and pile arrivals on the favored one
      if (plan_st.present[o] == '0) begin
        if (plan_st.present[fav] != '0) queue_event(tssa_pkg::ActDepart, fav);
        else queue_event(tssa_pkg::ActArrive, o);
      end else if (plan_st.present[o] > 1 && r < 12) begin
        queue_event(tssa_pkg::ActDepart, o);
      end else begin
        queue_event(tssa_pkg::ActArrive, fav);
      end
    end
  endtask

  // Sample at the falling edge so the check never races the driver
  task automatic wait_drained();
    while (pending_events.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [4:0] cap, input tssa_pkg::batch_t lim);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= tssa_pkg::CfgCapacity;
    cfg_wdata_i <= {1'b0, cap};
    @(posedge clk_i);
    cfg_idx_i   <= tssa_pkg::CfgBatchLimit;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    model_st.cap = cap;
    model_st.lim = lim;
    plan_st.cap  = cap;
    plan_st.lim  = lim;
    n_settings++;
  endtask

  task automatic run_phase(input logic [4:0] cap, input tssa_pkg::batch_t lim,
                           input traffic_e mode, input logic fav, input int unsigned n,
                           input bit pause_mid);
    wait_drained();
    write_cfg(cap, lim);
    for (int unsigned i = 0; i < n; i++) begin
      // pause the sender until every outstanding result is back
      if (pause_mid && i == n / 2) wait_drained();
      plan_event(mode, fav);
    end
  endtask

  initial begin
    model_st     = '0;
    model_st.cap = tssa_pkg::CapReset;
    model_st.lim = tssa_pkg::LimReset;
    plan_st      = model_st;
    idle_pct     = 20;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, at reset settings (capacity 4, batch limit 8)
    queue_event(tssa_pkg::ActDepart, 1'b0);            // departure from an empty resource
    queue_event(tssa_pkg::ActDepart, 1'b1);
    repeat (5) queue_event(tssa_pkg::ActArrive, 1'b0); // fill to capacity, the fifth waits
    repeat (2) queue_event(tssa_pkg::ActArrive, 1'b1); // blocked by the other side
    queue_event(tssa_pkg::ActDepart, 1'b0);            // same-side wake-up
    repeat (4) queue_event(tssa_pkg::ActDepart, 1'b0); // empty: hand over to the second side
    queue_event(tssa_pkg::ActArrive, 1'b0);
    repeat (2) queue_event(tssa_pkg::ActDepart, 1'b1); // hand back to the first side

    // Random phases over register extremes, including out-of-range values
    idle_pct = $urandom_range(3) * 10;
    run_phase(5'd16, 6'd32, TrafficMixed, 1'b0, 180, 1'b0);
    idle_pct = $urandom_range(3) * 10;
    run_phase(5'd1, 6'd1, TrafficMixed, 1'b0, 150, 1'b0);
    idle_pct = $urandom_range(3) * 10;
    run_phase(5'd0, 6'd0, TrafficMixed, 1'b1, 80, 1'b0);
    idle_pct = $urandom_range(3) * 10;
    run_phase(5'd31, 6'd63, TrafficOneSide, 1'b0, 150, 1'b0);
    idle_pct = $urandom_range(3) * 10;
    run_phase(5'd3, 6'd2, TrafficFlood, 1'b1, 320, 1'b0);
    idle_pct = $urandom_range(3) * 10;
    run_phase(5'd2, 6'd5, TrafficFlood, 1'b0, 320, 1'b0);
    idle_pct = 25;
    run_phase(5'd7, 6'd3, TrafficMixed, 1'b0, 100, 1'b1);
    // last stretch at full rate on both sides
    idle_pct = 0;
    run_phase(5'd5, 6'd4, TrafficMixed, 1'b1, 60, 1'b0);

    wait_drained();
    repeat (Settle) @(posedge clk_i);
    $display("checked %0d results over %0d register settings, widest admission run %0d",
             n_results, n_settings, widest_run);
    $display("queued arrivals %0d, refused on full wait count %0d, empty departures %0d",
             n_queued, n_refused, n_empty_depart);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("two_side_shared_resource_arbiter_top: match");
    end else begin
      $display("two_side_shared_resource_arbiter_top: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #(Period * 250000);
    $display("two_side_shared_resource_arbiter_top: mismatch");
    $finish;
  end

endmodule
